/* rtl/lebe_pkg.sv */
// Types, constants and the microprogram shared by the line editor buffer engine.
`default_nettype none

package lebe_pkg;

    localparam int OUT_W = 12;

    localparam logic [2:0] OP_CHAR  = 3'd0;
    localparam logic [2:0] OP_LEFT  = 3'd1;
    localparam logic [2:0] OP_RIGHT = 3'd2;
    localparam logic [2:0] OP_UP    = 3'd3;
    localparam logic [2:0] OP_DOWN  = 3'd4;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;

    // Microprogram addresses.
    typedef enum logic [4:0] {
        U_FIN, U_LEFT, U_RIGHT,
        U_INS0, U_INS_RD, U_INS_WR, U_INS_PUT,
        U_BS0, U_BS_RD, U_BS_WR, U_BS_END,
        U_UP0, U_UA_RD, U_UA_TST, U_UA_END, U_UB_RD, U_UB_TST, U_UB_END,
        U_DN0, U_DA_RD, U_DA_TST, U_DA_END, U_DB_RD, U_DB_TST, U_DB_END,
        U_DC_RD, U_DC_TST, U_DC_END, U_PLACE
    } upc_t;

    // Jump conditions.
    typedef enum logic [3:0] {
        C_NEVER, C_PTR_ZERO, C_PTR_CUR, C_PTR_FILL, C_PTR_INC_FILL,
        C_RD_LF, C_CUR_ZERO, C_CUR_FILL, C_FULL, C_OUT_BUSY
    } cond_t;

    // Datapath actions; an action runs only when the step's jump is not taken.
    typedef enum logic [4:0] {
        A_NONE, A_PTR_CUR, A_PTR_FILL, A_PTR_CUR_DEC, A_PTR_DEC, A_PTR_INC,
        A_MARK_DEC, A_MARK_CUR, A_UP_COL, A_DN_COL, A_DN_LEN, A_PLACE,
        A_CUR_DEC, A_CUR_INC, A_SHIFT_DN, A_SHIFT_UP, A_INSERT, A_RUB, A_DONE
    } act_t;

    // Read address select for the text store.
    typedef enum logic [1:0] {
        RA_PTR, RA_PTR_DEC, RA_PTR_INC
    } ra_t;

    typedef struct packed {
        cond_t cond;
        act_t  act;
        ra_t   ra;
        upc_t  jt;
        upc_t  jf;
    } ucw_t;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] key_code;
    } lebe_req_t;

    typedef struct packed {
        logic             changed;
        logic [OUT_W-1:0] cursor_pos;
        logic [OUT_W-1:0] text_length;
    } lebe_res_t;

    function automatic ucw_t uw(cond_t c, act_t a, ra_t r, upc_t t, upc_t f);
        ucw_t w;
        w.cond = c;
        w.act  = a;
        w.ra   = r;
        w.jt   = t;
        w.jf   = f;
        return w;
    endfunction

    // Control store: one word per step.
    function automatic ucw_t ucode(upc_t pc);
        ucw_t w;
        unique case (pc)
            U_FIN:     w = uw(C_OUT_BUSY,     A_DONE,        RA_PTR,     U_FIN,     U_FIN);
            U_LEFT:    w = uw(C_CUR_ZERO,     A_CUR_DEC,     RA_PTR,     U_FIN,     U_FIN);
            U_RIGHT:   w = uw(C_CUR_FILL,     A_CUR_INC,     RA_PTR,     U_FIN,     U_FIN);
            U_INS0:    w = uw(C_FULL,         A_PTR_FILL,    RA_PTR,     U_FIN,     U_INS_RD);
            U_INS_RD:  w = uw(C_PTR_CUR,      A_NONE,        RA_PTR_DEC, U_INS_PUT, U_INS_WR);
            U_INS_WR:  w = uw(C_NEVER,        A_SHIFT_DN,    RA_PTR,     U_FIN,     U_INS_RD);
            U_INS_PUT: w = uw(C_NEVER,        A_INSERT,      RA_PTR,     U_FIN,     U_FIN);
            U_BS0:     w = uw(C_CUR_ZERO,     A_PTR_CUR_DEC, RA_PTR,     U_FIN,     U_BS_RD);
            U_BS_RD:   w = uw(C_PTR_INC_FILL, A_NONE,        RA_PTR_INC, U_BS_END,  U_BS_WR);
            U_BS_WR:   w = uw(C_NEVER,        A_SHIFT_UP,    RA_PTR,     U_FIN,     U_BS_RD);
            U_BS_END:  w = uw(C_NEVER,        A_RUB,         RA_PTR,     U_FIN,     U_FIN);
            U_UP0:     w = uw(C_NEVER,        A_PTR_CUR,     RA_PTR,     U_FIN,     U_UA_RD);
            U_UA_RD:   w = uw(C_PTR_ZERO,     A_NONE,        RA_PTR_DEC, U_UA_END,  U_UA_TST);
            U_UA_TST:  w = uw(C_RD_LF,        A_PTR_DEC,     RA_PTR,     U_UA_END,  U_UA_RD);
            U_UA_END:  w = uw(C_PTR_ZERO,     A_MARK_DEC,    RA_PTR,     U_FIN,     U_UB_RD);
            U_UB_RD:   w = uw(C_PTR_ZERO,     A_NONE,        RA_PTR_DEC, U_UB_END,  U_UB_TST);
            U_UB_TST:  w = uw(C_RD_LF,        A_PTR_DEC,     RA_PTR,     U_UB_END,  U_UB_RD);
            U_UB_END:  w = uw(C_NEVER,        A_UP_COL,      RA_PTR,     U_FIN,     U_PLACE);
            U_DN0:     w = uw(C_NEVER,        A_PTR_CUR,     RA_PTR,     U_FIN,     U_DA_RD);
            U_DA_RD:   w = uw(C_PTR_ZERO,     A_NONE,        RA_PTR_DEC, U_DA_END,  U_DA_TST);
            U_DA_TST:  w = uw(C_RD_LF,        A_PTR_DEC,     RA_PTR,     U_DA_END,  U_DA_RD);
            U_DA_END:  w = uw(C_NEVER,        A_MARK_CUR,    RA_PTR,     U_FIN,     U_DB_RD);
            U_DB_RD:   w = uw(C_PTR_FILL,     A_NONE,        RA_PTR,     U_DB_END,  U_DB_TST);
            U_DB_TST:  w = uw(C_RD_LF,        A_PTR_INC,     RA_PTR,     U_DB_END,  U_DB_RD);
            U_DB_END:  w = uw(C_PTR_FILL,     A_DN_COL,      RA_PTR,     U_FIN,     U_DC_RD);
            U_DC_RD:   w = uw(C_PTR_FILL,     A_NONE,        RA_PTR,     U_DC_END,  U_DC_TST);
            U_DC_TST:  w = uw(C_RD_LF,        A_PTR_INC,     RA_PTR,     U_DC_END,  U_DC_RD);
            U_DC_END:  w = uw(C_NEVER,        A_DN_LEN,      RA_PTR,     U_FIN,     U_PLACE);
            U_PLACE:   w = uw(C_NEVER,        A_PLACE,       RA_PTR,     U_FIN,     U_FIN);
            default:   w = uw(C_NEVER,        A_NONE,        RA_PTR,     U_FIN,     U_FIN);
        endcase
        return w;
    endfunction

    // CR becomes LF and tab becomes space before anything else looks at the code.
    function automatic logic [7:0] map_key(logic [7:0] key);
        logic [7:0] k;
        k = key;
        if (key == CH_CR) begin
            k = CH_LF;
        end else if (key == CH_TAB) begin
            k = CH_SPACE;
        end
        return k;
    endfunction

    // Dispatch: first step of the microprogram for a request.
    function automatic upc_t entry_point(logic [2:0] op, logic [7:0] key);
        logic [7:0] k;
        upc_t       pc;
        k = map_key(key);
        unique case (op)
            OP_CHAR: begin
                priority if (k == CH_BS || k == CH_DEL) begin
                    pc = U_BS0;
                end else if (k[7]) begin
                    pc = U_FIN;
                end else if (k < CH_SPACE && k != CH_LF) begin
                    pc = U_FIN;
                end else begin
                    pc = U_INS0;
                end
            end
            OP_LEFT:  pc = U_LEFT;
            OP_RIGHT: pc = U_RIGHT;
            OP_UP:    pc = U_UP0;
            OP_DOWN:  pc = U_DN0;
            default:  pc = U_FIN;
        endcase
        return pc;
    endfunction

endpackage

`default_nettype wire

/* rtl/lebe_core.sv */
// Microcoded sequencer, datapath and text store of the line editor buffer engine.
`default_nettype none

module lebe_core #(
    parameter int STORE_BYTES = 4096
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire lebe_pkg::lebe_req_t req,
    input  wire logic              out_busy,
    output logic                   busy,
    output logic                   done,
    output lebe_pkg::lebe_res_t    res
);
    import lebe_pkg::*;

    localparam int ADDR_W = $clog2(STORE_BYTES);

    logic [7:0] mem [STORE_BYTES];

    upc_t              upc_reg, upc_next;
    logic              busy_reg, busy_next;
    logic              did_reg, did_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [ADDR_W-1:0] fill_reg, fill_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] mark_reg, mark_next;
    logic [ADDR_W-1:0] aux_reg, aux_next;
    logic [7:0]        char_reg, char_next;
    logic [7:0]        rdata_reg;

    ucw_t              cw;
    logic              hit;
    act_t              act;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] col_min;
    logic [ADDR_W:0]   ptr_inc_ext;
    logic [ADDR_W+OUT_W-1:0] cur_ext;
    logic [ADDR_W+OUT_W-1:0] fill_ext;

    assign cw          = ucode(upc_reg);
    assign ptr_inc_ext = {1'b0, ptr_reg} + 1'b1;
    assign col_min     = (aux_reg < ptr_reg) ? aux_reg : ptr_reg;

    always_comb begin
        unique case (cw.cond)
            C_NEVER:        hit = 1'b0;
            C_PTR_ZERO:     hit = (ptr_reg == '0);
            C_PTR_CUR:      hit = (ptr_reg == cur_reg);
            C_PTR_FILL:     hit = (ptr_reg == fill_reg);
            C_PTR_INC_FILL: hit = (ptr_inc_ext == {1'b0, fill_reg});
            C_RD_LF:        hit = (rdata_reg == CH_LF);
            C_CUR_ZERO:     hit = (cur_reg == '0);
            C_CUR_FILL:     hit = (cur_reg == fill_reg);
            C_FULL:         hit = (fill_reg == ADDR_W'(STORE_BYTES - 1));
            C_OUT_BUSY:     hit = out_busy;
            default:        hit = 1'b0;
        endcase
    end

    // Step counter: dispatch on a new request, otherwise follow the jump fields.
    always_comb begin
        upc_next = upc_reg;
        if (start) begin
            upc_next = entry_point(req.operation, req.key_code);
        end else if (busy_reg) begin
            upc_next = hit ? cw.jt : cw.jf;
        end
    end

    always_comb begin
        unique case (cw.ra)
            RA_PTR:     rd_addr = ptr_reg;
            RA_PTR_DEC: rd_addr = ptr_reg - 1'b1;
            RA_PTR_INC: rd_addr = ptr_reg + 1'b1;
            default:    rd_addr = ptr_reg;
        endcase
    end

    // Datapath control decoded from the current control word.
    always_comb begin
        act       = (busy_reg && !hit) ? cw.act : A_NONE;
        busy_next = busy_reg;
        did_next  = did_reg;
        cur_next  = cur_reg;
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        mark_next = mark_reg;
        aux_next  = aux_reg;
        char_next = char_reg;
        wr_en     = 1'b0;
        wr_addr   = ptr_reg;
        wr_data   = rdata_reg;
        done      = 1'b0;
        if (start) begin
            busy_next = 1'b1;
            did_next  = 1'b0;
            char_next = map_key(req.key_code);
        end
        unique case (act)
            A_NONE:        ;
            A_PTR_CUR:     ptr_next = cur_reg;
            A_PTR_FILL:    ptr_next = fill_reg;
            A_PTR_CUR_DEC: ptr_next = cur_reg - 1'b1;
            A_PTR_DEC:     ptr_next = ptr_reg - 1'b1;
            A_PTR_INC:     ptr_next = ptr_reg + 1'b1;
            A_MARK_DEC: begin
                mark_next = ptr_reg;
                ptr_next  = ptr_reg - 1'b1;
            end
            A_MARK_CUR: begin
                mark_next = ptr_reg;
                ptr_next  = cur_reg;
            end
            A_UP_COL: begin
                // Column on this line; previous line length is here - start - 1.
                aux_next  = cur_reg - mark_reg;
                mark_next = ptr_reg;
                ptr_next  = mark_reg + ~ptr_reg;
            end
            A_DN_COL: begin
                aux_next  = cur_reg - mark_reg;
                mark_next = ptr_reg + 1'b1;
                ptr_next  = ptr_reg + 1'b1;
            end
            A_DN_LEN:      ptr_next = ptr_reg - mark_reg;
            A_PLACE: begin
                cur_next = mark_reg + col_min;
                did_next = 1'b1;
            end
            A_CUR_DEC: begin
                cur_next = cur_reg - 1'b1;
                did_next = 1'b1;
            end
            A_CUR_INC: begin
                cur_next = cur_reg + 1'b1;
                did_next = 1'b1;
            end
            A_SHIFT_DN: begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg - 1'b1;
            end
            A_SHIFT_UP: begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + 1'b1;
            end
            A_INSERT: begin
                wr_en     = 1'b1;
                wr_addr   = cur_reg;
                wr_data   = char_reg;
                cur_next  = cur_reg + 1'b1;
                fill_next = fill_reg + 1'b1;
                did_next  = 1'b1;
            end
            A_RUB: begin
                cur_next  = cur_reg - 1'b1;
                fill_next = fill_reg - 1'b1;
                did_next  = 1'b1;
            end
            A_DONE: begin
                done      = 1'b1;
                busy_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg  <= U_FIN;
            busy_reg <= 1'b0;
            did_reg  <= 1'b0;
            cur_reg  <= '0;
            fill_reg <= '0;
        end else begin
            upc_reg  <= upc_next;
            busy_reg <= busy_next;
            did_reg  <= did_next;
            cur_reg  <= cur_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg  <= ptr_next;
        mark_reg <= mark_next;
        aux_reg  <= aux_next;
        char_reg <= char_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign cur_ext  = (ADDR_W + OUT_W)'(cur_reg);
    assign fill_ext = (ADDR_W + OUT_W)'(fill_reg);

    assign busy            = busy_reg;
    assign res.changed     = did_reg;
    assign res.cursor_pos  = cur_ext[OUT_W-1:0];
    assign res.text_length = fill_ext[OUT_W-1:0];

`ifndef SYNTHESIS
    a_cursor_in_text: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= fill_reg)
        else $error("cursor beyond end of text");

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= ADDR_W'(STORE_BYTES - 1))
        else $error("text length exceeds store");

    a_idle_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |=> $stable(cur_reg) && $stable(fill_reg))
        else $error("cursor or length moved while idle");

    a_fill_steps_by_one: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(fill_reg) |->
            (fill_reg == ADDR_W'($past(fill_reg) + 1'b1)) ||
            (fill_reg == ADDR_W'($past(fill_reg) - 1'b1)))
        else $error("text length changed by more than one");
`endif

endmodule

`default_nettype wire

/* rtl/line_editor_buffer_engine.sv */
// Top level of the line editor buffer engine: stream ports and result register.
`default_nettype none

// Line editor buffer engine. Each request is one key event (operation in s_tuser,
// character in s_tdata); each produces exactly one result word with the changed
// flag, the new cursor and the text length. Requests are handled one at a time by
// a microcoded sequencer over a single-port text store with a registered read, so
// every character shifted or scanned takes a read step followed by a write or test
// step. An insert or backspace shifts each character after the cursor, up scans
// back over the current and previous lines and down over the current and next
// lines. A finished result waits in the output register while the next request is
// accepted.
module line_editor_buffer_engine #(
    parameter int STORE_BYTES = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] key_code
    input  wire logic [2:0]  s_tuser,   // [2:0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [0] changed, [12:1] cursor_pos, [24:13] text_length
);
    import lebe_pkg::*;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic        start;
    logic        busy;
    logic        done;
    logic        out_busy;
    lebe_req_t   req;
    lebe_res_t   res;

    assign s_tready      = !busy;
    assign start         = s_tvalid && s_tready;
    assign req.operation = s_tuser;
    assign req.key_code  = s_tdata;
    assign out_busy      = m_tvalid_reg && !m_tready;

    lebe_core #(
        .STORE_BYTES(STORE_BYTES)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .req      (req),
        .out_busy (out_busy),
        .busy     (busy),
        .done     (done),
        .res      (res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (done) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {7'd0, res.text_length, res.cursor_pos, res.changed};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking stream testbench for the line editor buffer engine with a key-event predictor.
`timescale 1ns / 1ps

module testbench;

    import lebe_pkg::*;

    localparam int STORE_BYTES = 4096;
    localparam int QUIET_LIMIT = 40000;
    localparam int SETTLE_CYCLES = 20;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    typedef enum logic [1:0] {
        GAPS_NONE, GAPS_SENDER, GAPS_RECEIVER, GAPS_BOTH
    } gap_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    gap_mode_t   gap_mode = GAPS_NONE;
    lebe_req_t   key_events[$];
    lebe_res_t   expected_status[$];
    int          keys_sent = 0;
    int          keys_taken = 0;
    int          fail_count = 0;
    int          quiet_cycles = 0;

    // Shadow copy of the editor state.
    logic [7:0]  text_mem [STORE_BYTES];
    int          text_len = 0;
    int          caret = 0;

    line_editor_buffer_engine #(
        .STORE_BYTES(STORE_BYTES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int line_head(int at);
        int p;
        p = (at > text_len) ? text_len : at;
        while (p > 0 && text_mem[p-1] != CH_LF) p--;
        return p;
    endfunction

    function automatic int line_tail(int at);
        int p;
        p = (at > text_len) ? text_len : at;
        while (p < text_len && text_mem[p] != CH_LF) p++;
        return p;
    endfunction

    // Applies one key event to the shadow state and returns the status it reports.
    function automatic lebe_res_t apply_key_event(lebe_req_t rq);
        lebe_res_t  rs;
        logic [7:0] k;
        logic       did;
        int         here, stop, ls, le, col, j;
        did = 1'b0;
        case (rq.operation)
            OP_CHAR: begin
                k = rq.key_code;
                if (k == CH_CR) begin
                    k = CH_LF;
                end else if (k == CH_TAB) begin
                    k = CH_SPACE;
                end
                if (k == CH_BS || k == CH_DEL) begin
                    if (caret > 0 && text_len > 0) begin
                        for (j = caret - 1; j + 1 < text_len; j++) text_mem[j] = text_mem[j+1];
                        text_len--;
                        caret--;
                        did = 1'b1;
                    end
                end else if (k >= 8'd128 || (k < CH_SPACE && k != CH_LF)) begin
                    did = 1'b0;
                end else if (text_len + 1 < STORE_BYTES) begin
                    for (j = text_len; j > caret; j--) text_mem[j] = text_mem[j-1];
                    text_mem[caret] = k;
                    text_len++;
                    caret++;
                    did = 1'b1;
                end
            end
            OP_LEFT: begin
                if (caret > 0) begin
                    caret--;
                    did = 1'b1;
                end
            end
            OP_RIGHT: begin
                if (caret < text_len) begin
                    caret++;
                    did = 1'b1;
                end
            end
            OP_UP: begin
                here = line_head(caret);
                if (here != 0) begin
                    le = here - 1;
                    ls = line_head(le);
                    col = caret - here;
                    if (col > le - ls) col = le - ls;
                    caret = ls + col;
                    did = 1'b1;
                end
            end
            OP_DOWN: begin
                here = line_head(caret);
                stop = line_tail(caret);
                if (stop < text_len) begin
                    ls = stop + 1;
                    le = line_tail(ls);
                    col = caret - here;
                    if (col > le - ls) col = le - ls;
                    caret = ls + col;
                    did = 1'b1;
                end
            end
            default: did = 1'b0;
        endcase
        rs.changed = did;
        rs.cursor_pos = caret[OUT_W-1:0];
        rs.text_length = text_len[OUT_W-1:0];
        return rs;
    endfunction

    function automatic void queue_key(logic [2:0] op, logic [7:0] code);
        lebe_req_t rq;
        rq.operation = op;
        rq.key_code = code;
        key_events.push_back(rq);
    endfunction

    // Mostly printable text and line breaks with cursor motion, plus some junk.
    function automatic void queue_random_key();
        int pick;
        int sub;
        pick = $urandom_range(99);
        sub = $urandom_range(99);
        if (pick < 45) begin
            if (sub < 55) begin
                queue_key(OP_CHAR, 8'($urandom_range(32, 126)));
            end else if (sub < 65) begin
                queue_key(OP_CHAR, CH_LF);
            end else if (sub < 70) begin
                queue_key(OP_CHAR, CH_CR);
            end else if (sub < 75) begin
                queue_key(OP_CHAR, CH_TAB);
            end else if (sub < 80) begin
                queue_key(OP_CHAR, CH_BS);
            end else if (sub < 85) begin
                queue_key(OP_CHAR, CH_DEL);
            end else if (sub < 92) begin
                queue_key(OP_CHAR, 8'($urandom_range(0, 31)));
            end else begin
                queue_key(OP_CHAR, 8'($urandom_range(128, 255)));
            end
        end else if (pick < 57) begin
            queue_key(OP_LEFT, 8'($urandom_range(255)));
        end else if (pick < 69) begin
            queue_key(OP_RIGHT, 8'($urandom_range(255)));
        end else if (pick < 81) begin
            queue_key(OP_UP, 8'($urandom_range(255)));
        end else if (pick < 93) begin
            queue_key(OP_DOWN, 8'($urandom_range(255)));
        end else begin
            queue_key(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                      8'($urandom_range(255)));
        end
    endfunction

    function automatic logic gap_now(gap_mode_t mode, logic sender);
        int pct;
        case (mode)
            GAPS_SENDER:   pct = sender ? 80 : 0;
            GAPS_RECEIVER: pct = sender ? 0 : 80;
            GAPS_BOTH:     pct = 30;
            default:       pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    task automatic drain();
        while (key_events.size() != 0 || keys_sent != keys_taken ||
               expected_status.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // Request driver: a new request is presented only once the previous one was taken.
    always @(negedge aclk) begin
        lebe_req_t rq;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (keys_sent == keys_taken) begin
            if (key_events.size() != 0 && !gap_now(gap_mode, 1'b1)) begin
                rq = key_events.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= rq.key_code;
                s_tuser <= rq.operation;
                keys_sent++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= !gap_now(gap_mode, 1'b0);
    end

    // Monitor: checks results, then predicts for the request taken at this edge.
    always @(posedge aclk) begin
        lebe_res_t want;
        lebe_req_t rq;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_status.size() == 0) begin
                    fail_count++;
                    $error("result: none expected, actual %h", m_tdata);
                end else begin
                    want = expected_status.pop_front();
                    check_field("changed", want.changed, m_tdata[0]);
                    check_field("cursor_pos", want.cursor_pos, m_tdata[12:1]);
                    check_field("text_length", want.text_length, m_tdata[24:13]);
                end
            end
            if (s_tvalid && s_tready) begin
                rq.operation = s_tuser;
                rq.key_code = s_tdata;
                expected_status.push_back(apply_key_event(rq));
                keys_taken++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL line_editor_buffer_engine");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty text: every motion and deletion is a no-op, and junk codes are rejected.
        queue_key(OP_LEFT, 8'hFF);
        queue_key(OP_RIGHT, 8'h00);
        queue_key(OP_UP, 8'hAA);
        queue_key(OP_DOWN, 8'h55);
        queue_key(OP_CHAR, CH_BS);
        queue_key(OP_CHAR, CH_DEL);
        queue_key(OP_CHAR, 8'd0);
        queue_key(OP_CHAR, 8'd31);
        queue_key(OP_CHAR, 8'd128);
        queue_key(OP_CHAR, 8'd255);
        queue_key(OP_UNUSED_FIRST, 8'h41);
        queue_key(OP_UNUSED_LAST, 8'h41);
        // Builds three lines, using the CR and tab mappings along the way, then moves and edits across them.
        queue_key(OP_CHAR, 8'h61);
        queue_key(OP_CHAR, CH_TAB);
        queue_key(OP_CHAR, CH_CR);
        queue_key(OP_CHAR, 8'd126);
        queue_key(OP_CHAR, CH_SPACE);
        queue_key(OP_CHAR, CH_LF);
        queue_key(OP_CHAR, 8'h62);
        queue_key(OP_UP, 8'h00);
        queue_key(OP_UP, 8'h00);
        queue_key(OP_DOWN, 8'h00);
        queue_key(OP_LEFT, 8'h00);
        queue_key(OP_CHAR, 8'h5A);
        queue_key(OP_CHAR, CH_BS);
        queue_key(OP_CHAR, CH_DEL);
        queue_key(OP_RIGHT, 8'h00);
        queue_key(3'd6, 8'h00);
        drain();

        gap_mode = GAPS_NONE;
        repeat (18) queue_random_key();
        drain();
        gap_mode = GAPS_SENDER;
        repeat (18) queue_random_key();
        drain();
        gap_mode = GAPS_RECEIVER;
        repeat (18) queue_random_key();
        drain();
        gap_mode = GAPS_BOTH;
        repeat (18) queue_random_key();
        drain();

        if (fail_count == 0) begin
            $display("PASS line_editor_buffer_engine");
        end else begin
            $display("FAIL line_editor_buffer_engine");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/lebe_pkg.sv
rtl/lebe_core.sv
rtl/line_editor_buffer_engine.sv
dv/testbench.sv
